>>> rtl/pem_pkg.sv
`timescale 1ns / 1ps

package pem_pkg;

   // Field widths of the transaction payloads and the control port.
   localparam int MODE_W      = 3;
   localparam int TIME_W      = 32;
   localparam int HOUR_W      = 5;
   localparam int DAY_W       = 5;
   localparam int COUNT_W     = 32;
   localparam int WATTS_W     = 16;
   localparam int SECS_W      = 23;
   localparam int CFG_W       = 16;
   localparam int CSR_INDEX_W = 1;

   // Divisor is pulses_per_kwh times the pulse period.
   localparam int DEN_W       = CFG_W + TIME_W;
   localparam int DIV_STEPS   = TIME_W;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

   // Register indexes of the control port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPK      = 1'd1;

   // Register reset values.
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd80;
   localparam logic [CFG_W-1:0] PPK_RESET      = 16'd3200;

   // Transaction modes.
   localparam logic [MODE_W-1:0] MODE_STATUS    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PULSE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLR_DAY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLR_MONTH = 3'd4;

   // Milliseconds per hour times watts per kilowatt.
   localparam logic [TIME_W-1:0] CONV_NUMERATOR = 32'd3600000000;
   localparam logic [WATTS_W-1:0] WATTS_MAX = 16'hFFFF;

   // Division by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38;
   // exact for every 32-bit dividend.
   localparam int SECS_RECIP_W = 29;
   localparam logic [SECS_RECIP_W-1:0] SECS_RECIP = 29'd274877907;
   localparam int SECS_SHIFT = 38;
   localparam int SECS_PROD_W = TIME_W + SECS_RECIP_W;

   // Calendar values that trigger the day and month stamps.
   localparam logic [HOUR_W-1:0] MIDNIGHT_HOUR = 5'd0;
   localparam logic [DAY_W-1:0]  FIRST_DAY     = 5'd1;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CALC,
      SEQ_DIV,
      SEQ_FIN
   } seq_state_type;

   // Divider control and status.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> rtl/pem_req_if.sv
`timescale 1ns / 1ps

interface pem_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pem_pkg::MODE_W-1:0]           mode;
   logic [pem_pkg::TIME_W-1:0]           now_ms;
   logic [pem_pkg::HOUR_W-1:0]           hour;
   logic [pem_pkg::DAY_W-1:0]            day_of_month;
   logic                                 time_valid;
   logic [pem_pkg::COUNT_W-1:0]          load_value;

   modport source (
      output valid, mode, now_ms, hour, day_of_month, time_valid, load_value,
      input  ready
   );

   modport sink (
      input  valid, mode, now_ms, hour, day_of_month, time_valid, load_value,
      output ready
   );
endinterface

>>> rtl/pem_rsp_if.sv
`timescale 1ns / 1ps

interface pem_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 accepted;
   logic [pem_pkg::WATTS_W-1:0]          watts;
   logic [pem_pkg::COUNT_W-1:0]          total_pulses;
   logic [pem_pkg::COUNT_W-1:0]          day_count;
   logic [pem_pkg::COUNT_W-1:0]          month_count;
   logic [pem_pkg::COUNT_W-1:0]          last_month_count;
   logic [pem_pkg::SECS_W-1:0]           seconds_since_pulse;

   modport source (
      output valid, accepted, watts, total_pulses, day_count, month_count,
             last_month_count, seconds_since_pulse,
      input  ready
   );

   modport sink (
      input  valid, accepted, watts, total_pulses, day_count, month_count,
             last_month_count, seconds_since_pulse,
      output ready
   );
endinterface

>>> rtl/pem_div.sv
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, most significant first.
module pem_div (
   input  logic                          clock,
   input  logic                          reset,
   input  pem_pkg::div_ctl_type          ctl,
   input  logic [pem_pkg::TIME_W-1:0]    dividend,
   input  logic [pem_pkg::DEN_W-1:0]     divisor,
   output pem_pkg::div_sts_type          sts,
   output logic [pem_pkg::TIME_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pem_pkg::DIV_COUNT_W-1:0]   count_ff, count_in;
   logic [pem_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [pem_pkg::DEN_W-1:0]         divisor_ff, divisor_in;
   logic [pem_pkg::TIME_W-1:0]        quo_ff, quo_in;
   logic [pem_pkg::DEN_W:0]           trial;
   logic [pem_pkg::DEN_W:0]           diff;
   logic                              fits;

   // One step: shift in the next dividend bit and subtract when it fits.
   assign trial = {rem_ff, quo_ff[pem_pkg::TIME_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (ctl.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[pem_pkg::DEN_W-1:0] : trial[pem_pkg::DEN_W-1:0];
         quo_in   = {quo_ff[pem_pkg::TIME_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == pem_pkg::DIV_COUNT_W'(pem_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/pulse_energy_meter_top.sv
`timescale 1ns / 1ps

// A counted pulse with a nonzero period product passes through the calculation state, the
// divider steps up to its done flag and the finish state; every other transaction goes from
// the calculation state straight to the finish state. The input is ready only when idle,
// so a new transaction is taken only after the previous result is loaded, and that load
// waits while the output register holds a result not yet taken. Reset (synchronous, active
// high) clears the control and architectural state and loads debounce 80, constant 3200.
module pulse_energy_meter_top (
   input  logic                                clock,
   input  logic                                reset,
   pem_req_if.sink                             req_ch,
   pem_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [pem_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pem_pkg::CFG_W-1:0]           csr_wdata
);

   // Configuration registers.
   logic [pem_pkg::CFG_W-1:0] debounce_ff;
   logic [pem_pkg::CFG_W-1:0] ppk_ff;

   // Sequencer.
   pem_pkg::seq_state_type state_ff, state_in;
   logic req_fire;
   logic fin_load;

   // Captured transaction.
   logic [pem_pkg::MODE_W-1:0]  mode_ff;
   logic [pem_pkg::TIME_W-1:0]  now_ff;
   logic [pem_pkg::HOUR_W-1:0]  hour_ff;
   logic [pem_pkg::DAY_W-1:0]   mday_ff;
   logic                        tvalid_ff;
   logic [pem_pkg::COUNT_W-1:0] load_ff;
   logic [pem_pkg::TIME_W-1:0]  elapsed_ff;

   // Products and flags formed in the calculation cycle.
   logic [pem_pkg::SECS_PROD_W-1:0] secs_prod;
   logic [pem_pkg::DEN_W-1:0]       den;
   logic                            acc_calc;
   logic [pem_pkg::SECS_W-1:0]      secs_ff;
   logic                            acc_ff;
   logic                            den_zero_ff;

   // Architectural state.
   logic [pem_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [pem_pkg::COUNT_W-1:0] day_base_ff, day_base_in;
   logic [pem_pkg::COUNT_W-1:0] month_base_ff, month_base_in;
   logic [pem_pkg::TIME_W-1:0]  last_pulse_ff, last_pulse_in;
   logic [pem_pkg::WATTS_W-1:0] watts_ff, watts_in;
   logic [pem_pkg::COUNT_W-1:0] published_ff, published_in;
   logic [pem_pkg::COUNT_W-1:0] prev_month_ff, prev_month_in;
   logic [pem_pkg::HOUR_W-1:0]  seen_hour_ff, seen_hour_in;
   logic [pem_pkg::DAY_W-1:0]   seen_day_ff, seen_day_in;

   // Output register.
   logic                        rsp_valid_ff;
   logic                        rsp_acc_ff;
   logic [pem_pkg::WATTS_W-1:0] rsp_watts_ff;
   logic [pem_pkg::COUNT_W-1:0] rsp_total_ff;
   logic [pem_pkg::COUNT_W-1:0] rsp_day_ff;
   logic [pem_pkg::COUNT_W-1:0] rsp_month_ff;
   logic [pem_pkg::COUNT_W-1:0] rsp_last_month_ff;
   logic [pem_pkg::SECS_W-1:0]  rsp_secs_ff;

   // Divider for the power quotient.
   pem_pkg::div_ctl_type        div_ctl;
   pem_pkg::div_sts_type        div_sts;
   logic [pem_pkg::TIME_W-1:0]  div_quo;

   pem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (pem_pkg::CONV_NUMERATOR),
      .divisor  (den),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= pem_pkg::DEBOUNCE_RESET;
         ppk_ff      <= pem_pkg::PPK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pem_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            pem_pkg::CSR_PPK:      ppk_ff      <= csr_wdata;
         endcase
      end
   end

   // Period product for power and reciprocal product for seconds.
   assign den       = pem_pkg::DEN_W'(elapsed_ff) * pem_pkg::DEN_W'(ppk_ff);
   assign secs_prod = elapsed_ff * pem_pkg::SECS_RECIP;
   assign acc_calc  = (mode_ff == pem_pkg::MODE_PULSE) &&
                      (elapsed_ff >= pem_pkg::TIME_W'(debounce_ff));

   assign req_fire = req_ch.valid && req_ch.ready;

   // Sequencer next state and control.
   always_comb begin
      state_in      = state_ff;
      req_ch.ready  = 1'b0;
      div_ctl.start = 1'b0;
      fin_load      = 1'b0;
      unique case (state_ff)
         pem_pkg::SEQ_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = pem_pkg::SEQ_CALC;
            end
         end
         pem_pkg::SEQ_CALC: begin
            if (acc_calc && (den != '0)) begin
               div_ctl.start = 1'b1;
               state_in      = pem_pkg::SEQ_DIV;
            end else begin
               state_in = pem_pkg::SEQ_FIN;
            end
         end
         pem_pkg::SEQ_DIV: begin
            if (div_sts.done) begin
               state_in = pem_pkg::SEQ_FIN;
            end
         end
         pem_pkg::SEQ_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               fin_load = 1'b1;
               state_in = pem_pkg::SEQ_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pem_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the transaction and the time since the last counted pulse.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_ch.mode;
         now_ff     <= req_ch.now_ms;
         hour_ff    <= req_ch.hour;
         mday_ff    <= req_ch.day_of_month;
         tvalid_ff  <= req_ch.time_valid;
         load_ff    <= req_ch.load_value;
         elapsed_ff <= req_ch.now_ms - last_pulse_ff;
      end
      if (state_ff == pem_pkg::SEQ_CALC) begin
         secs_ff     <= secs_prod[pem_pkg::SECS_PROD_W-1:pem_pkg::SECS_SHIFT];
         acc_ff      <= acc_calc;
         den_zero_ff <= (den == '0);
      end
   end

   // Mode action, then the calendar stamps, then the published month count.
   always_comb begin
      total_in      = total_ff;
      day_base_in   = day_base_ff;
      month_base_in = month_base_ff;
      last_pulse_in = last_pulse_ff;
      watts_in      = watts_ff;
      prev_month_in = prev_month_ff;
      seen_hour_in  = seen_hour_ff;
      seen_day_in   = seen_day_ff;

      unique case (mode_ff)
         pem_pkg::MODE_PULSE: begin
            if (acc_ff) begin
               total_in      = total_ff + 1'b1;
               last_pulse_in = now_ff;
               if (!den_zero_ff) begin
                  watts_in = (div_quo > pem_pkg::TIME_W'(pem_pkg::WATTS_MAX)) ?
                             pem_pkg::WATTS_MAX : div_quo[pem_pkg::WATTS_W-1:0];
               end
            end
         end
         pem_pkg::MODE_LOAD:      total_in      = load_ff;
         pem_pkg::MODE_CLR_DAY:   day_base_in   = total_ff;
         pem_pkg::MODE_CLR_MONTH: month_base_in = total_ff;
         default: ;
      endcase

      if (tvalid_ff) begin
         if ((hour_ff == pem_pkg::MIDNIGHT_HOUR) &&
             (seen_hour_ff != pem_pkg::MIDNIGHT_HOUR)) begin
            day_base_in = total_in;
            if ((mday_ff == pem_pkg::FIRST_DAY) && (seen_day_ff != pem_pkg::FIRST_DAY)) begin
               prev_month_in = published_ff;
               month_base_in = total_in;
            end
         end
         seen_hour_in = hour_ff;
         seen_day_in  = mday_ff;
      end

      published_in = total_in - month_base_in;
   end

   // Commit the state when the result is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         day_base_ff   <= '0;
         month_base_ff <= '0;
         last_pulse_ff <= '0;
         watts_ff      <= '0;
         published_ff  <= '0;
         prev_month_ff <= '0;
         seen_hour_ff  <= '0;
         seen_day_ff   <= '0;
      end else if (fin_load) begin
         total_ff      <= total_in;
         day_base_ff   <= day_base_in;
         month_base_ff <= month_base_in;
         last_pulse_ff <= last_pulse_in;
         watts_ff      <= watts_in;
         published_ff  <= published_in;
         prev_month_ff <= prev_month_in;
         seen_hour_ff  <= seen_hour_in;
         seen_day_ff   <= seen_day_in;
      end
   end

   // Output register: valid holds until the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_acc_ff        <= acc_ff && (mode_ff == pem_pkg::MODE_PULSE);
         rsp_watts_ff      <= watts_in;
         rsp_total_ff      <= total_in;
         rsp_day_ff        <= total_in - day_base_in;
         rsp_month_ff      <= published_in;
         rsp_last_month_ff <= prev_month_in;
         rsp_secs_ff       <= secs_ff;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.accepted            = rsp_acc_ff;
   assign rsp_ch.watts               = rsp_watts_ff;
   assign rsp_ch.total_pulses        = rsp_total_ff;
   assign rsp_ch.day_count           = rsp_day_ff;
   assign rsp_ch.month_count         = rsp_month_ff;
   assign rsp_ch.last_month_count    = rsp_last_month_ff;
   assign rsp_ch.seconds_since_pulse = rsp_secs_ff;

   // The divider is running or just finished whenever the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pem_pkg::SEQ_DIV) |-> (div_sts.busy || div_sts.done))
      else $error("sequencer waits on an idle divider");

   // The divider is never restarted while a division is in progress.
   assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");

   // A counted pulse advances the total by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (fin_load && acc_ff && (mode_ff == pem_pkg::MODE_PULSE)) |=>
      (total_ff == pem_pkg::COUNT_W'($past(total_ff) + 1'b1)))
      else $error("counted pulse did not advance the total by one");

endmodule

>>> dv/pulse_energy_meter_top_test.sv
`timescale 1ns / 1ps

module pulse_energy_meter_top_test;

   // Milliseconds per hour times watts per kilowatt, wide enough for the divide.
   localparam logic [63:0]                WATT_MS_PER_KWH = 64'd3600000000;
   localparam logic [pem_pkg::TIME_W-1:0] MS_PER_SEC      = 32'd1000;
   localparam logic [pem_pkg::HOUR_W-1:0] LAST_HOUR       = 5'd23;
   localparam logic [pem_pkg::DAY_W-1:0]  LAST_DAY        = 5'd31;
   localparam int                         QUIET_LIMIT     = 2000;
   localparam int                         DRAIN_CYCLES    = 60;

   typedef struct {
      logic [pem_pkg::MODE_W-1:0]  mode;
      logic [pem_pkg::TIME_W-1:0]  now_ms;
      logic [pem_pkg::HOUR_W-1:0]  hour;
      logic [pem_pkg::DAY_W-1:0]   day_of_month;
      logic                        time_valid;
      logic [pem_pkg::COUNT_W-1:0] load_value;
   } meter_item_type;

   typedef struct {
      logic                        accepted;
      logic [pem_pkg::WATTS_W-1:0] watts;
      logic [pem_pkg::COUNT_W-1:0] total_pulses;
      logic [pem_pkg::COUNT_W-1:0] day_count;
      logic [pem_pkg::COUNT_W-1:0] month_count;
      logic [pem_pkg::COUNT_W-1:0] last_month_count;
      logic [pem_pkg::SECS_W-1:0]  seconds_since_pulse;
   } meter_reading_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [pem_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pem_pkg::CFG_W-1:0]       csr_wdata;

   pem_req_if req_if();
   pem_rsp_if rsp_if();

   pulse_energy_meter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Meter shadow: configuration and state as they stand after reset.
   logic [pem_pkg::CFG_W-1:0]   cfg_debounce = pem_pkg::DEBOUNCE_RESET;
   logic [pem_pkg::CFG_W-1:0]   cfg_ppk      = pem_pkg::PPK_RESET;
   logic [pem_pkg::COUNT_W-1:0] m_total      = '0;
   logic [pem_pkg::COUNT_W-1:0] m_day_base   = '0;
   logic [pem_pkg::COUNT_W-1:0] m_month_base = '0;
   logic [pem_pkg::TIME_W-1:0]  m_last_pulse = '0;
   logic [pem_pkg::WATTS_W-1:0] m_watts      = '0;
   logic [pem_pkg::COUNT_W-1:0] m_published  = '0;
   logic [pem_pkg::COUNT_W-1:0] m_prev_month = '0;
   logic [pem_pkg::HOUR_W-1:0]  m_seen_hour  = '0;
   logic [pem_pkg::DAY_W-1:0]   m_seen_day   = '0;

   meter_item_type    pending_items[$];
   meter_reading_type expected_readings[$];

   int   fail_count  = 0;
   logic steady_flow = 1'b0;

   // Stimulus clock and calendar that the random items follow.
   logic [pem_pkg::TIME_W-1:0] gen_ms   = '0;
   logic [pem_pkg::HOUR_W-1:0] gen_hour = 5'd5;
   logic [pem_pkg::DAY_W-1:0]  gen_day  = 5'd1;

   // Applies one transaction to the shadow state and returns the reading it produces.
   function automatic meter_reading_type next_reading(meter_item_type it);
      logic [pem_pkg::TIME_W-1:0] elapsed;
      logic [47:0]                den;
      logic [63:0]                quotient;
      meter_reading_type          rd;
      elapsed = it.now_ms - m_last_pulse;
      rd.accepted = 1'b0;
      rd.seconds_since_pulse = pem_pkg::SECS_W'(elapsed / MS_PER_SEC);
      case (it.mode)
         pem_pkg::MODE_PULSE: begin
            if (elapsed >= cfg_debounce) begin
               rd.accepted = 1'b1;
               m_total = m_total + 1'b1;
               m_last_pulse = it.now_ms;
               den = cfg_ppk * elapsed;
               // A zero meter constant or zero period keeps the old power.
               if (den != '0) begin
                  quotient = WATT_MS_PER_KWH / den;
                  m_watts = (quotient > pem_pkg::WATTS_MAX) ? pem_pkg::WATTS_MAX :
                            quotient[pem_pkg::WATTS_W-1:0];
               end
            end
         end
         pem_pkg::MODE_LOAD:      m_total = it.load_value;
         pem_pkg::MODE_CLR_DAY:   m_day_base = m_total;
         pem_pkg::MODE_CLR_MONTH: m_month_base = m_total;
         default: ;
      endcase
      // Midnight stamps the day base; midnight on the first day also closes the month.
      if (it.time_valid) begin
         if (it.hour == pem_pkg::MIDNIGHT_HOUR && m_seen_hour != pem_pkg::MIDNIGHT_HOUR) begin
            m_day_base = m_total;
            if (it.day_of_month == pem_pkg::FIRST_DAY && m_seen_day != pem_pkg::FIRST_DAY) begin
               m_prev_month = m_published;
               m_month_base = m_total;
            end
         end
         m_seen_hour = it.hour;
         m_seen_day = it.day_of_month;
      end
      m_published = m_total - m_month_base;
      rd.watts = m_watts;
      rd.total_pulses = m_total;
      rd.day_count = m_total - m_day_base;
      rd.month_count = m_published;
      rd.last_month_count = m_prev_month;
      return rd;
   endfunction

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int idle_length();
      int r;
      if (steady_flow) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 88) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 80));
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Driver: presents queued transactions and records each accepted one.
   meter_item_type cur_item;
   int             send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_readings.push_back(next_reading(cur_item));
            send_gap = idle_length();
         end
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_if.mode         <= cur_item.mode;
            req_if.now_ms       <= cur_item.now_ms;
            req_if.hour         <= cur_item.hour;
            req_if.day_of_month <= cur_item.day_of_month;
            req_if.time_valid   <= cur_item.time_valid;
            req_if.load_value   <= cur_item.load_value;
            req_if.valid        <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: compares each reading with the oldest expected one and stalls at random.
   meter_reading_type want;
   int                recv_stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               $error("reading arrived with no transaction outstanding");
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("accepted", want.accepted, rsp_if.accepted);
               check_field("watts", want.watts, rsp_if.watts);
               check_field("total_pulses", want.total_pulses, rsp_if.total_pulses);
               check_field("day_count", want.day_count, rsp_if.day_count);
               check_field("month_count", want.month_count, rsp_if.month_count);
               check_field("last_month_count", want.last_month_count,
                           rsp_if.last_month_count);
               check_field("seconds_since_pulse", want.seconds_since_pulse,
                           rsp_if.seconds_since_pulse);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_stall = idle_length();
         end
      end
   end

   // Watchdog: too long without any transaction on either side ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[pulse_energy_meter_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_item(input logic [pem_pkg::MODE_W-1:0] mode,
                           input logic [pem_pkg::TIME_W-1:0] now,
                           input logic [pem_pkg::HOUR_W-1:0] hour,
                           input logic [pem_pkg::DAY_W-1:0] day,
                           input logic tv, input logic [pem_pkg::COUNT_W-1:0] load);
      meter_item_type it;
      it.mode = mode;
      it.now_ms = now;
      it.hour = hour;
      it.day_of_month = day;
      it.time_valid = tv;
      it.load_value = load;
      pending_items.push_back(it);
   endtask

   // Waits until every transaction has been sent and answered, then lets the block settle.
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_if.valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pem_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [pem_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == pem_pkg::CSR_DEBOUNCE) cfg_debounce = value;
      else cfg_ppk = value;
   endtask

   // Random transactions: mostly pulses around the debounce spacing on a running clock,
   // with a calendar that reaches midnight and the first of the month often.
   task automatic queue_random(input int count);
      meter_item_type             it;
      int                         r;
      int                         c;
      logic [pem_pkg::TIME_W-1:0] step;
      for (int n = 0; n < count; n++) begin
         r = int'($urandom_range(0, 99));
         if (r < 58) it.mode = pem_pkg::MODE_PULSE;
         else if (r < 68) it.mode = pem_pkg::MODE_STATUS;
         else if (r < 73) it.mode = pem_pkg::MODE_LOAD;
         else if (r < 80) it.mode = pem_pkg::MODE_CLR_DAY;
         else if (r < 86) it.mode = pem_pkg::MODE_CLR_MONTH;
         else if (r < 92)
            it.mode = pem_pkg::MODE_CLR_MONTH + pem_pkg::MODE_W'($urandom_range(1, 3));
         else it.mode = pem_pkg::MODE_PULSE;

         r = int'($urandom_range(0, 99));
         if (r < 20) step = (cfg_debounce > 1) ? $urandom_range(0, cfg_debounce - 1) : '0;
         else if (r < 30) step = cfg_debounce;
         else if (r < 35) step = cfg_debounce + 1;
         else if (r < 70) step = cfg_debounce + $urandom_range(0, 2000);
         else if (r < 90) step = $urandom_range(0, 100000);
         else if (r < 96) step = $urandom_range(0, 10000000);
         else step = $urandom();
         gen_ms = gen_ms + step;
         it.now_ms = gen_ms;

         r = int'($urandom_range(0, 99));
         if (r < 80) begin
            c = int'($urandom_range(0, 99));
            if (c < 12) begin
               if (gen_hour >= LAST_HOUR) begin
                  gen_hour = pem_pkg::MIDNIGHT_HOUR;
                  gen_day = ($urandom_range(0, 3) == 0 || gen_day >= LAST_DAY) ?
                            pem_pkg::FIRST_DAY : gen_day + 1'b1;
               end else begin
                  gen_hour = gen_hour + 1'b1;
               end
            end else if (c < 16) begin
               gen_hour = LAST_HOUR;
            end
            it.hour = gen_hour;
            it.day_of_month = gen_day;
            it.time_valid = ($urandom_range(0, 19) != 0);
         end else begin
            it.hour = pem_pkg::HOUR_W'($urandom_range(0, 31));
            it.day_of_month = pem_pkg::DAY_W'($urandom_range(0, 31));
            it.time_valid = ($urandom_range(0, 1) != 0);
         end

         r = int'($urandom_range(0, 3));
         if (r < 2) it.load_value = $urandom();
         else if (r == 2) it.load_value = 32'hFFFF_FFFF - $urandom_range(0, 20);
         else it.load_value = $urandom_range(0, 1000);
         pending_items.push_back(it);
      end
   endtask

   task automatic run_phase(input logic [pem_pkg::CFG_W-1:0] debounce,
                            input logic [pem_pkg::CFG_W-1:0] ppk,
                            input int count, input logic steady);
      wait_drained();
      write_csr(pem_pkg::CSR_DEBOUNCE, debounce);
      write_csr(pem_pkg::CSR_PPK, ppk);
      steady_flow = steady;
      queue_random(count);
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.mode         = pem_pkg::MODE_STATUS;
      req_if.now_ms       = '0;
      req_if.hour         = '0;
      req_if.day_of_month = '0;
      req_if.time_valid   = 1'b0;
      req_if.load_value   = '0;
      rsp_if.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = pem_pkg::CSR_DEBOUNCE;
      csr_wdata           = '0;
      reset               = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset configuration.
      add_item(pem_pkg::MODE_STATUS, 32'd0, 5'd0, 5'd0, 1'b0, 32'd0);
      // A bounce right after reset, then a pulse exactly at the debounce spacing.
      add_item(pem_pkg::MODE_PULSE, 32'd50, 5'd0, 5'd0, 1'b0, 32'd0);
      add_item(pem_pkg::MODE_PULSE, 32'd80, 5'd0, 5'd0, 1'b0, 32'd0);
      add_item(pem_pkg::MODE_PULSE, 32'd81, 5'd0, 5'd0, 1'b0, 32'd0);
      // Longest period: power falls to zero and the seconds reach their top.
      add_item(pem_pkg::MODE_PULSE, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b0, 32'd0);
      // Total loaded at its maximum, then a pulse across the timestamp wrap.
      add_item(pem_pkg::MODE_LOAD, 32'hFFFF_FFFF, 5'd0, 5'd0, 1'b0, 32'hFFFF_FFFF);
      add_item(pem_pkg::MODE_PULSE, 32'd200, 5'd0, 5'd0, 1'b0, 32'hFFFF_FFFF);
      add_item(pem_pkg::MODE_CLR_DAY, 32'd300, 5'd0, 5'd0, 1'b0, 32'd0);
      add_item(pem_pkg::MODE_PULSE, 32'd400, 5'd0, 5'd0, 1'b0, 32'd0);
      add_item(pem_pkg::MODE_CLR_MONTH, 32'd500, 5'd0, 5'd0, 1'b0, 32'd0);
      // Unused modes behave as status.
      add_item(pem_pkg::MODE_CLR_MONTH + 3'd1, 32'd600, 5'd0, 5'd0, 1'b0, 32'd5);
      add_item(pem_pkg::MODE_CLR_MONTH + 3'd2, 32'd600, 5'd0, 5'd0, 1'b0, 32'd5);
      add_item(pem_pkg::MODE_CLR_MONTH + 3'd3, 32'd600, 5'd0, 5'd0, 1'b0, 32'd5);
      // The first midnight after reset does not stamp.
      add_item(pem_pkg::MODE_STATUS, 32'd700, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b1, 32'd0);
      add_item(pem_pkg::MODE_PULSE, 32'd1000, LAST_HOUR, LAST_DAY, 1'b1, 32'd0);
      // Midnight on the first of the month stamps day and month, only once.
      add_item(pem_pkg::MODE_PULSE, 32'd2000, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b1, 32'd0);
      add_item(pem_pkg::MODE_STATUS, 32'd2100, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b1, 32'd0);
      add_item(pem_pkg::MODE_PULSE, 32'd3000, 5'd3, 5'd5, 1'b1, 32'd0);
      // Invalid time neither stamps nor updates the seen hour.
      add_item(pem_pkg::MODE_PULSE, 32'd4000, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b0, 32'd0);
      add_item(pem_pkg::MODE_STATUS, 32'd4100, pem_pkg::MIDNIGHT_HOUR, 5'd2, 1'b1, 32'd0);
      // Out of range clock fields, then a month change seen from day 31.
      add_item(pem_pkg::MODE_PULSE, 32'd5000, 5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF);
      add_item(pem_pkg::MODE_PULSE, 32'd6000, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b1, 32'd0);
      add_item(pem_pkg::MODE_STATUS, 32'd6000, 5'd31, pem_pkg::FIRST_DAY, 1'b1, 32'd0);
      // Midnight while day 1 was already seen stamps the day only.
      add_item(pem_pkg::MODE_STATUS, 32'd7000, pem_pkg::MIDNIGHT_HOUR, pem_pkg::FIRST_DAY,
               1'b1, 32'd0);
      gen_ms = 32'd7000;

      // Random part over several settings, the extremes and zero values among them.
      run_phase(pem_pkg::DEBOUNCE_RESET, pem_pkg::PPK_RESET, 250, 1'b0);
      run_phase(16'd1, 16'd1, 250, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 200, 1'b1);
      run_phase(16'd0, pem_pkg::PPK_RESET, 200, 1'b0);
      run_phase(16'd20, 16'd0, 200, 1'b0);
      repeat (3)
         run_phase(pem_pkg::CFG_W'($urandom_range(1, 300)),
                   pem_pkg::CFG_W'($urandom_range(1, 65535)), 200,
                   $urandom_range(0, 3) == 0);
      run_phase(pem_pkg::CFG_W'($urandom_range(0, 65535)),
                pem_pkg::CFG_W'($urandom_range(0, 65535)), 150, 1'b0);
      wait_drained();

      if (fail_count == 0) begin
         $display("[pulse_energy_meter_top] OK");
      end else begin
         $display("[pulse_energy_meter_top] ERROR");
      end
      $finish;
   end

endmodule
